@@ hdl/alid_pkg.sv @@
// Shared types and codes for the array list insert/delete unit.
// Used by alid_cell and array_list_insert_delete_unit; depends on nothing.
package alid_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT   = 2'd0,
        MODE_DEL_HEAD = 2'd1,
        MODE_DEL_TAIL = 2'd2,
        MODE_READ     = 2'd3
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_EMPTY  = 2'd2,
        STATUS_BADPOS = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT_DOWN
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [WORD_W-1:0]  value;
    } t_cell_ctl;

endpackage

@@ hdl/alid_cell.sv @@
// One storage cell of the list chain: holds one word and trades it with its neighbors.
// Depends on alid_pkg for the cell control struct.
module alid_cell import alid_pkg::*; #(
    parameter int unsigned IW    = 4,
    parameter int unsigned INDEX = 0
) (
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [IW-1:0]     i_pos,
    input  logic [IW-1:0]     i_rd_idx,
    input  logic [WORD_W-1:0] i_left,
    input  logic [WORD_W-1:0] i_right,
    output logic [WORD_W-1:0] o_data,
    output logic [WORD_W-1:0] o_rd
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            CELL_INSERT: begin
                if (MY_IDX == i_pos) begin
                    n_data = i_ctl.value;
                end else if (MY_IDX > i_pos) begin
                    n_data = i_left;
                end
            end
            CELL_SHIFT_DOWN: begin
                n_data = i_right;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = (MY_IDX == i_rd_idx) ? r_data : '0;

endmodule

@@ hdl/array_list_insert_delete_unit.sv @@
// Top level of the array list insert/delete unit: control, count and result register.
// Depends on alid_pkg and instantiates a chain of alid_cell.
//
// Usage: requests enter on i_valid/o_stall with i_mode, i_position and i_value_in.
// A request is taken at a clock edge where i_valid is high and o_stall is low.
// Results leave on o_valid/i_stall with o_value_out, o_entry_count and o_status.
// Each request yields exactly one result, registered at the edge that accepts it.
// Throughput is one request per cycle while o_stall is low: all cells shift, load or
// hold in the same cycle, so inserts and head deletes take no longer than reads.
// The result register holds one result; while it is full and i_stall is high,
// o_stall is raised and the list state does not change. A result leaving in the
// same cycle frees the register for the next request.
// Reset clears the entry count and the output valid flag. Stored words are not
// cleared; only entries below the count are ever returned.
// Refused requests (full, empty, bad position) leave the list unchanged and return
// zero in o_value_out.
module array_list_insert_delete_unit import alid_pkg::*; #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [MODE_W-1:0]         i_mode,
    input  logic [POS_W-1:0]          i_position,
    input  logic signed [WORD_W-1:0]  i_value_in,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic signed [WORD_W-1:0]  o_value_out,
    output logic [COUNT_W-1:0]        o_entry_count,
    output logic [STATUS_W-1:0]       o_status
);

    localparam int unsigned CW    = $clog2(DEPTH + 1);
    localparam int unsigned IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CMP_W = (CW > POS_W) ? CW : POS_W;

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_out_valid;
    logic [WORD_W-1:0]     r_value_out;
    logic [COUNT_W-1:0]    r_entry_count;
    t_status               r_status;

    logic                  accept;
    logic [CMP_W-1:0]      pos_x;
    logic [CMP_W-1:0]      cnt_x;
    t_cell_op              op;
    t_status               status;
    logic [WORD_W-1:0]     result;
    logic [IW-1:0]         rd_idx;
    logic [WORD_W-1:0]     rd_data;
    t_cell_ctl             ctl;

    logic [WORD_W-1:0]     cell_data [DEPTH];
    logic [WORD_W-1:0]     cell_rd   [DEPTH];

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;
    assign pos_x   = CMP_W'(i_position);
    assign cnt_x   = CMP_W'(r_count);

    always_comb begin
        op      = CELL_HOLD;
        status  = STATUS_OK;
        result  = '0;
        rd_idx  = '0;
        n_count = r_count;
        unique case (t_mode'(i_mode))
            MODE_INSERT: begin
                if (cnt_x >= CMP_W'(DEPTH)) begin
                    status = STATUS_FULL;
                end else if (pos_x > cnt_x) begin
                    status = STATUS_BADPOS;
                end else begin
                    op      = CELL_INSERT;
                    n_count = CW'(r_count + 1'b1);
                end
            end
            MODE_DEL_HEAD: begin
                if (r_count == '0) begin
                    status = STATUS_EMPTY;
                end else begin
                    rd_idx  = '0;
                    result  = rd_data;
                    op      = CELL_SHIFT_DOWN;
                    n_count = CW'(r_count - 1'b1);
                end
            end
            MODE_DEL_TAIL: begin
                if (r_count == '0) begin
                    status = STATUS_EMPTY;
                end else begin
                    rd_idx  = IW'(r_count - 1'b1);
                    result  = rd_data;
                    n_count = CW'(r_count - 1'b1);
                end
            end
            MODE_READ: begin
                if (pos_x >= cnt_x) begin
                    status = STATUS_BADPOS;
                end else begin
                    rd_idx = IW'(pos_x);
                    result = rd_data;
                end
            end
            default: begin
                status = STATUS_BADPOS;
            end
        endcase
    end

    assign ctl.op    = accept ? op : CELL_HOLD;
    assign ctl.value = i_value_in;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [WORD_W-1:0] left;
        logic [WORD_W-1:0] right;
        if (k == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_left
            assign left = cell_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign right = cell_data[k];
        end else begin : g_mid_right
            assign right = cell_data[k+1];
        end
        alid_cell #(
            .IW    (IW),
            .INDEX (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (ctl),
            .i_pos    (IW'(pos_x)),
            .i_rd_idx (rd_idx),
            .i_left   (left),
            .i_right  (right),
            .o_data   (cell_data[k]),
            .o_rd     (cell_rd[k])
        );
    end

    always_comb begin
        rd_data = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_data = rd_data | cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value_out   <= result;
            r_entry_count <= COUNT_W'(n_count);
            r_status      <= status;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_value_out   = r_value_out;
    assign o_entry_count = r_entry_count;
    assign o_status      = r_status;

endmodule
